// ----- sv/pimt_pkg.sv -----
// shared types and constants for the interval merge table
package pimt_pkg;

  localparam int ChromW = 16;
  localparam int CoordW = 31;
  localparam int HitsW  = 32;
  localparam int PadW   = 10;
  localparam int DepthW = 16;
  localparam int StatW  = 3;

  localparam logic [StatW-1:0] StInserted = 3'd0;
  localparam logic [StatW-1:0] StMerged   = 3'd1;
  localparam logic [StatW-1:0] StFull     = 3'd2;
  localparam logic [StatW-1:0] StPopped   = 3'd3;
  localparam logic [StatW-1:0] StEmpty    = 3'd4;

  localparam logic CmdInsert = 1'b0;
  localparam logic CmdPop    = 1'b1;

  localparam logic RegPadK     = 1'b0;
  localparam logic RegMinDepth = 1'b1;

  typedef struct packed {
    logic [ChromW-1:0] chrom;
    logic [CoordW-1:0] first;
    logic [CoordW-1:0] last;
    logic [HitsW-1:0]  hits;
  } entry_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MERGE,
    S_PLACE,
    S_DISCARD,
    S_POP,
    S_OUT
  } state_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic   absorb;     // the first cell in reach takes itself out this cycle, the cells right of it shift left
    logic   place;      // insert the carried entry in sorted order
    logic   shift_out;  // remove the head cell
    entry_t carried;
    logic [PadW:0] pad2;
  } cell_ctl_t;

  function automatic logic [HitsW-1:0] sat_add(input logic [HitsW-1:0] a,
                                                input logic [HitsW-1:0] b);
    logic [HitsW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[HitsW] ? {HitsW{1'b1}} : s[HitsW-1:0];
  endfunction

endpackage

// ----- sv/pimt_cell.sv -----
// one table slot: holds an entry, compares it with the carried entry, shifts
module pimt_cell (
  input  logic               clk,
  input  logic               rst,
  input  pimt_pkg::cell_ctl_t ctl,
  input  logic               left_valid,
  input  pimt_pkg::entry_t   left_entry,
  input  logic               left_before,   // left neighbor sorts before carried
  input  logic               left_absorb_any, // some cell left of here absorbs
  input  logic               right_valid,
  input  pimt_pkg::entry_t   right_entry,
  output logic               valid,
  output pimt_pkg::entry_t   entry,
  output logic               ahead,         // this cell sorts before carried
  output logic               hit,           // this cell merges with carried
  output logic               absorb_any     // this cell or one left of it absorbs
);

  pimt_pkg::entry_t entry_next;
  logic             valid_next;
  logic [pimt_pkg::CoordW+1:0] end_a, end_b;

  // padded reach test against the carried interval
  always_comb begin
    end_a = {2'b00, ctl.carried.last} + {{(pimt_pkg::CoordW+1-pimt_pkg::PadW){1'b0}}, ctl.pad2};
    end_b = {2'b00, entry.last} + {{(pimt_pkg::CoordW+1-pimt_pkg::PadW){1'b0}}, ctl.pad2};
    hit = valid && (entry.chrom == ctl.carried.chrom) &&
          (end_a >= {2'b00, entry.first}) && (end_b >= {2'b00, ctl.carried.first});
    ahead = valid && ((entry.chrom < ctl.carried.chrom) ||
            ((entry.chrom == ctl.carried.chrom) && (entry.first <= ctl.carried.first)));
    absorb_any = left_absorb_any || (hit && !left_absorb_any);
  end

  // first hit leaves; everything right of it moves one place left
  // on placement the carried entry lands right after the cells that sort ahead
  always_comb begin
    valid_next = valid;
    entry_next = entry;
    if (ctl.shift_out || (ctl.absorb && absorb_any)) begin
      valid_next = right_valid;
      entry_next = right_entry;
    end else if (ctl.place && !ahead && left_valid) begin
      valid_next = 1'b1;
      entry_next = left_before ? ctl.carried : left_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    entry <= entry_next;
  end

endmodule

// ----- sv/pimt_ctrl.sv -----
// sequencer: takes a command, runs merge passes, placement or pops, holds the result
module pimt_ctrl #(
  parameter int CntW = 9
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_take,
  input  logic                         command,
  input  logic [pimt_pkg::ChromW-1:0]  chrom,
  input  logic [pimt_pkg::CoordW-1:0]  interval_start,
  input  logic [pimt_pkg::CoordW-1:0]  interval_end,
  input  logic [pimt_pkg::PadW-1:0]    pad_k,
  input  logic [pimt_pkg::DepthW-1:0]  min_depth,
  input  logic                         any_hit,
  input  logic                         full,
  input  logic                         head_valid,
  input  pimt_pkg::entry_t             head,
  input  logic [CntW-1:0]              held,
  input  pimt_pkg::entry_t             grown,
  input  logic                         out_take,
  output pimt_pkg::cell_ctl_t          ctl,
  output logic                         busy,
  output logic                         res_valid,
  output logic [pimt_pkg::StatW-1:0]   status,
  output pimt_pkg::entry_t             res_entry,
  output logic [CntW-1:0]              res_held
);

  pimt_pkg::state_t state, state_next;
  pimt_pkg::entry_t carried, carried_next;
  logic merged, merged_next;
  logic [pimt_pkg::StatW-1:0] status_next;
  pimt_pkg::entry_t res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pimt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
    carried   <= carried_next;
    merged    <= merged_next;
    status    <= status_next;
    res_entry <= res_next;
  end

  // held count is passed through unregistered; the table is quiet while the result shows
  assign res_held  = held;
  assign res_valid = (state == pimt_pkg::S_OUT);
  assign busy      = (state != pimt_pkg::S_IDLE);

  always_comb begin
    state_next   = state;
    carried_next = carried;
    merged_next  = merged;
    status_next  = status;
    res_next     = res_entry;
    ctl          = '0;
    ctl.carried  = carried;
    ctl.pad2     = {pad_k, 1'b0};
    unique case (state)
      pimt_pkg::S_IDLE: begin
        if (in_take) begin
          carried_next.chrom = chrom;
          carried_next.first = interval_start;
          carried_next.last  = (interval_end < interval_start) ? interval_start : interval_end;
          carried_next.hits  = 32'd1;
          merged_next = 1'b0;
          res_next    = '0;
          state_next  = (command == pimt_pkg::CmdPop) ? pimt_pkg::S_DISCARD : pimt_pkg::S_MERGE;
        end
      end
      pimt_pkg::S_MERGE: begin
        // absorb one entry per cycle, growing the carried interval
        if (any_hit) begin
          ctl.absorb   = 1'b1;
          merged_next  = 1'b1;
          carried_next = grown;
          state_next   = pimt_pkg::S_MERGE;
        end else if (!merged && full) begin
          status_next = pimt_pkg::StFull;
          state_next  = pimt_pkg::S_OUT;
        end else begin
          status_next = merged ? pimt_pkg::StMerged : pimt_pkg::StInserted;
          state_next  = pimt_pkg::S_PLACE;
        end
      end
      pimt_pkg::S_PLACE: begin
        ctl.place  = 1'b1;
        state_next = pimt_pkg::S_OUT;
      end
      pimt_pkg::S_DISCARD: begin
        if (head_valid && (head.hits < {16'd0, min_depth})) begin
          ctl.shift_out = 1'b1;
        end else begin
          state_next = pimt_pkg::S_POP;
        end
      end
      pimt_pkg::S_POP: begin
        if (head_valid) begin
          ctl.shift_out = 1'b1;
          res_next      = head;
          status_next   = pimt_pkg::StPopped;
        end else begin
          status_next   = pimt_pkg::StEmpty;
        end
        state_next = pimt_pkg::S_OUT;
      end
      pimt_pkg::S_OUT: begin
        if (out_take) state_next = pimt_pkg::S_IDLE;
      end
      default: state_next = pimt_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- sv/padded_interval_merge_table_unit.sv -----
// top level: sorted interval table built as a shifting row of cells
//
// Keeps up to CAPACITY disjoint intervals sorted by chromosome and start.
// Input channel: in_valid/in_stall with command, chrom, interval_start,
// interval_end. Output channel: out_valid/out_stall with one result per item
// (status, out_chrom, out_start, out_end, out_count, entries_held).
// Configuration: cfg_valid/cfg_ready with cfg_index (0 pad_k, 1 min_depth)
// and cfg_data; always ready, write only while idle.
// An insert shows its result once the sequencer has absorbed every entry
// in reach, one absorb per cycle of the cell row (the first cell in reach
// drops out and the row closes up), found nothing left in reach and placed
// the grown interval. A dropped insert on a full table shows its result once
// the merge pass finds nothing in reach, with nothing placed. A pop discards
// the entries below min_depth, one per cycle at the head cell, then pops the
// head if there is one. One item is in flight at a time; the next is taken
// only after the result transfer, once the sequencer is back in idle. The
// result register holds while out_stall is high and no new item is taken.
// Reset empties the row at once (valid bit per cell) and restores
// pad_k to 25 and min_depth to 1.
module padded_interval_merge_table_unit #(
  parameter int CAPACITY = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         command,
  input  logic [15:0]                  chrom,
  input  logic [30:0]                  interval_start,
  input  logic [30:0]                  interval_end,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   status,
  output logic [15:0]                  out_chrom,
  output logic [30:0]                  out_start,
  output logic [30:0]                  out_end,
  output logic [31:0]                  out_count,
  output logic [$clog2(CAPACITY+1)-1:0] entries_held,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [15:0]                  cfg_data
);

  localparam int CntW = $clog2(CAPACITY+1);

  logic [pimt_pkg::PadW-1:0]   pad_k;
  logic [pimt_pkg::DepthW-1:0] min_depth;
  pimt_pkg::cell_ctl_t ctl;
  logic busy, any_hit;
  pimt_pkg::entry_t res_entry;

  logic             cv   [CAPACITY+1];
  pimt_pkg::entry_t ce   [CAPACITY+1];
  logic             cb   [CAPACITY];
  logic             ch   [CAPACITY];
  logic             cab  [CAPACITY];
  logic [CntW-1:0]  held;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_k     <= 10'd25;
      min_depth <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == pimt_pkg::RegPadK) pad_k <= cfg_data[pimt_pkg::PadW-1:0];
      else if (cfg_index == pimt_pkg::RegMinDepth) min_depth <= cfg_data;
    end
  end

  // occupancy counter follows the row
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (ctl.place) begin
      held <= held + 1'b1;
    end else if (ctl.shift_out || (ctl.absorb && any_hit)) begin
      held <= held - 1'b1;
    end
  end

  // carried entry accumulates absorbed cells
  pimt_pkg::entry_t hit_entry;
  always_comb begin
    hit_entry = '0;
    for (int i = CAPACITY-1; i >= 0; i--) begin
      if (ch[i]) hit_entry = ce[i];
    end
  end

  assign cv[CAPACITY] = 1'b0;
  assign ce[CAPACITY] = '0;
  assign any_hit = cab[CAPACITY-1];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_row
    pimt_cell u_cell (
      .clk            (clk),
      .rst            (rst),
      .ctl            (ctl),
      .left_valid     ((g == 0) ? 1'b1 : cv[(g == 0) ? 0 : g-1]),
      .left_entry     ((g == 0) ? ctl.carried : ce[(g == 0) ? 0 : g-1]),
      .left_before    ((g == 0) ? 1'b1 : cb[(g == 0) ? 0 : g-1]),
      .left_absorb_any((g == 0) ? 1'b0 : cab[(g == 0) ? 0 : g-1]),
      .right_valid    (cv[g+1]),
      .right_entry    (ce[g+1]),
      .valid          (cv[g]),
      .entry          (ce[g]),
      .ahead          (cb[g]),
      .hit            (ch[g]),
      .absorb_any     (cab[g])
    );
  end

  pimt_pkg::entry_t grown;
  always_comb begin
    grown.chrom = ctl.carried.chrom;
    grown.first = (hit_entry.first < ctl.carried.first) ? hit_entry.first : ctl.carried.first;
    grown.last  = (hit_entry.last > ctl.carried.last) ? hit_entry.last : ctl.carried.last;
    grown.hits  = pimt_pkg::sat_add(ctl.carried.hits, hit_entry.hits);
  end

  pimt_ctrl #(.CntW(CntW)) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_take       (in_valid && !in_stall),
    .command       (command),
    .chrom         (chrom),
    .interval_start(interval_start),
    .interval_end  (interval_end),
    .pad_k         (pad_k),
    .min_depth     (min_depth),
    .any_hit       (any_hit),
    .full          (held == CntW'(CAPACITY)),
    .head_valid    (cv[0]),
    .head          (ce[0]),
    .held          (held),
    .grown         (grown),
    .out_take      (out_valid && !out_stall),
    .ctl           (ctl),
    .busy          (busy),
    .res_valid     (out_valid),
    .status        (status),
    .res_entry     (res_entry),
    .res_held      (entries_held)
  );

  assign out_chrom = res_entry.chrom;
  assign out_start = res_entry.first;
  assign out_end   = res_entry.last;
  assign out_count = res_entry.hits;

  // occupancy never exceeds the row
  assert property (@(posedge clk) disable iff (rst) held <= CntW'(CAPACITY))
    else $error("occupancy above capacity");
  // a new item is never taken while a result is held
  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("item taken with result pending");
  // held count drops by one per head shift-out
  assert property (@(posedge clk) disable iff (rst)
    ctl.shift_out |=> (held == $past(held) - 1'b1))
    else $error("count mismatch on shift");

endmodule

// ----- test/padded_interval_merge_table_checker.sv -----
// checker for the interval merge table: tracks config and table, compares results
`timescale 1ns / 100ps
module padded_interval_merge_table_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              command,
  input  logic [15:0]       chrom,
  input  logic [30:0]       interval_start,
  input  logic [30:0]       interval_end,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [2:0]        status,
  input  logic [15:0]       out_chrom,
  input  logic [30:0]       out_start,
  input  logic [30:0]       out_end,
  input  logic [31:0]       out_count,
  input  logic [8:0]        entries_held,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data,
  output int                errors,
  output int                pending,
  output int                n_merged,
  output int                n_full,
  output int                n_popped,
  output int                n_empty
);

  typedef struct packed {
    logic [pimt_pkg::StatW-1:0]  stat;
    logic [pimt_pkg::ChromW-1:0] chrom;
    logic [pimt_pkg::CoordW-1:0] first;
    logic [pimt_pkg::CoordW-1:0] last;
    logic [pimt_pkg::HitsW-1:0]  hits;
    logic [8:0]                  held;
  } outcome_t;

  localparam int Cap = 256;

  pimt_pkg::entry_t             table_q[$];
  outcome_t                     outcome_q[$];
  logic [pimt_pkg::PadW-1:0]    pad_k;
  logic [pimt_pkg::DepthW-1:0]  min_depth;

  function automatic logic [pimt_pkg::HitsW-1:0] hits_sum(
      input logic [pimt_pkg::HitsW-1:0] a, input logic [pimt_pkg::HitsW-1:0] b);
    logic [pimt_pkg::HitsW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[pimt_pkg::HitsW] ? '1 : s[pimt_pkg::HitsW-1:0];
  endfunction

  function automatic bit in_reach(pimt_pkg::entry_t a, pimt_pkg::entry_t b);
    longint unsigned p2;
    p2 = 2 * longint'(pad_k);
    if (a.chrom != b.chrom) return 0;
    return (longint'(a.last) + p2 >= longint'(b.first)) &&
           (longint'(b.last) + p2 >= longint'(a.first));
  endfunction

  // sorted placement after entries with same key or lower
  function automatic void place_entry(pimt_pkg::entry_t e);
    int p;
    p = 0;
    while (p < table_q.size() && (table_q[p].chrom < e.chrom ||
           (table_q[p].chrom == e.chrom && table_q[p].first <= e.first)))
      p++;
    table_q.insert(p, e);
  endfunction

  function automatic outcome_t apply_command(logic cmd, logic [15:0] c,
                                             logic [30:0] s, logic [30:0] e);
    outcome_t         o;
    pimt_pkg::entry_t grown;
    bit               merged, changed;
    o = '0;
    if (cmd == pimt_pkg::CmdInsert) begin
      grown.chrom = c;
      grown.first = s;
      grown.last  = (e < s) ? s : e;
      grown.hits  = 32'd1;
      merged = 0;
      changed = 1;
      // absorb until nothing is left within the padding
      while (changed) begin
        changed = 0;
        for (int i = 0; i < table_q.size(); i++) begin
          if (in_reach(grown, table_q[i])) begin
            if (table_q[i].first < grown.first) grown.first = table_q[i].first;
            if (table_q[i].last > grown.last) grown.last = table_q[i].last;
            grown.hits = hits_sum(grown.hits, table_q[i].hits);
            table_q.delete(i);
            merged = 1;
            changed = 1;
            break;
          end
        end
      end
      if (merged) begin
        place_entry(grown);
        o.stat = pimt_pkg::StMerged;
      end else if (table_q.size() >= Cap) begin
        o.stat = pimt_pkg::StFull;
      end else begin
        place_entry(grown);
        o.stat = pimt_pkg::StInserted;
      end
    end else begin
      while (table_q.size() > 0 && table_q[0].hits < min_depth) void'(table_q.pop_front());
      if (table_q.size() > 0) begin
        o.chrom = table_q[0].chrom;
        o.first = table_q[0].first;
        o.last  = table_q[0].last;
        o.hits  = table_q[0].hits;
        void'(table_q.pop_front());
        o.stat = pimt_pkg::StPopped;
      end else begin
        o.stat = pimt_pkg::StEmpty;
      end
    end
    o.held = 9'(table_q.size());
    return o;
  endfunction

  // watch config, input and output transfers
  always @(posedge clk) begin
    outcome_t exp_o;
    if (rst) begin
      pad_k <= 10'd25;
      min_depth <= 16'd1;
      table_q.delete();
      outcome_q.delete();
      errors <= 0;
      pending <= 0;
      n_merged <= 0; n_full <= 0; n_popped <= 0; n_empty <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pimt_pkg::RegPadK) pad_k <= cfg_data[pimt_pkg::PadW-1:0];
        else if (cfg_index == pimt_pkg::RegMinDepth) min_depth <= cfg_data;
      end
      if (in_valid && !in_stall) begin
        exp_o = apply_command(command, chrom, interval_start, interval_end);
        outcome_q.push_back(exp_o);
        case (exp_o.stat)
          pimt_pkg::StMerged: n_merged <= n_merged + 1;
          pimt_pkg::StFull:   n_full <= n_full + 1;
          pimt_pkg::StPopped: n_popped <= n_popped + 1;
          pimt_pkg::StEmpty:  n_empty <= n_empty + 1;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result status %0d", $time, status);
          errors <= errors + 1;
        end else begin
          exp_o = outcome_q.pop_front();
          if ({status, out_chrom, out_start, out_end, out_count, entries_held} !== exp_o) begin
            $display("%0t: expected st=%0d c=%0d s=%0d e=%0d n=%0d held=%0d", $time,
                     exp_o.stat, exp_o.chrom, exp_o.first, exp_o.last, exp_o.hits, exp_o.held);
            $display("%0t: actual   st=%0d c=%0d s=%0d e=%0d n=%0d held=%0d", $time,
                     status, out_chrom, out_start, out_end, out_count, entries_held);
            errors <= errors + 1;
          end
        end
      end
      pending <= outcome_q.size();
    end
  end

endmodule

// ----- test/padded_interval_merge_table_unit_tb.sv -----
// testbench top for the interval merge table: stimulus and verdict
`timescale 1ns / 100ps
module padded_interval_merge_table_unit_tb;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic        command = pimt_pkg::CmdInsert;
  logic [15:0] chrom = 0;
  logic [30:0] interval_start = 0;
  logic [30:0] interval_end = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [2:0]  status;
  logic [15:0] out_chrom;
  logic [30:0] out_start;
  logic [30:0] out_end;
  logic [31:0] out_count;
  logic [8:0]  entries_held;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        cfg_index = pimt_pkg::RegPadK;
  logic [15:0] cfg_data = 0;

  int  errors, pending, n_merged, n_full, n_popped, n_empty;
  bit  quiet = 0;      // no idling in the last part
  bit  hold_off = 0;   // request a long receiver stall
  int  n_sent = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  padded_interval_merge_table_unit u_dut (.*);

  padded_interval_merge_table_checker u_chk (.*);

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // receiver stalls: random bursts, plus one long hold-off
  initial begin
    int n;
    @(posedge clk);
    while (1) begin
      if (hold_off) begin
        out_stall <= 1;
        repeat (400) @(posedge clk);
        out_stall <= 0;
        hold_off = 0;
        @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 4);
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
        @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  // one transfer on the input channel, with an optional gap before it
  task automatic send_item(logic cmd, logic [15:0] c, logic [30:0] s, logic [30:0] e);
    int g;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      g = $urandom_range(1, 4);
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    command <= cmd;
    chrom <= c;
    interval_start <= s;
    interval_end <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // random interval on a few chromosomes inside a small window, now and then a fully random one
  task automatic random_item(int pop_pct, int span);
    logic [30:0] s, e;
    logic [15:0] c;
    c = 16'($urandom_range(0, 3));
    s = 31'($urandom_range(0, span));
    e = s + 31'($urandom_range(0, 60));
    if ($urandom_range(0, 30) == 0) begin
      c = 16'($urandom);
      s = 31'($urandom);
      e = 31'($urandom);
    end
    send_item($urandom_range(0, 99) < pop_pct ? pimt_pkg::CmdPop : pimt_pkg::CmdInsert,
              c, s, e);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes and special cases at reset settings
    send_item(pimt_pkg::CmdPop, 0, 0, 0);
    send_item(pimt_pkg::CmdInsert, 16'hFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
    send_item(pimt_pkg::CmdInsert, 0, 0, 0);
    send_item(pimt_pkg::CmdInsert, 0, 100, 40);
    send_item(pimt_pkg::CmdInsert, 0, 150, 160);
    send_item(pimt_pkg::CmdInsert, 0, 49, 99);
    send_item(pimt_pkg::CmdInsert, 16'hFFFF, 31'h7FFFFFC0, 31'h7FFFFFD0);
    send_item(pimt_pkg::CmdInsert, 5, 31'h55555555, 31'h2AAAAAAA);
    send_item(pimt_pkg::CmdPop, 0, 0, 0);
    send_item(pimt_pkg::CmdPop, 0, 0, 0);
    send_item(pimt_pkg::CmdPop, 0, 0, 0);
    send_item(pimt_pkg::CmdPop, 0, 0, 0);
    send_item(pimt_pkg::CmdPop, 0, 0, 0);
    drain();

    // no padding, then fill the table to overflow
    write_reg(pimt_pkg::RegPadK, 0);
    write_reg(pimt_pkg::RegMinDepth, 0);
    for (int i = 0; i < 260; i++)
      send_item(pimt_pkg::CmdInsert, 1, 31'(i * 10), 31'(i * 10 + 1));
    // bridge the whole row into one entry
    send_item(pimt_pkg::CmdInsert, 1, 0, 3000);
    send_item(pimt_pkg::CmdPop, 0, 0, 0);
    send_item(pimt_pkg::CmdPop, 0, 0, 0);
    drain();

    // widest padding, depth filter, long receiver hold-off
    write_reg(pimt_pkg::RegPadK, 1023);
    write_reg(pimt_pkg::RegMinDepth, 3);
    hold_off = 1;
    for (int i = 0; i < 400; i++) random_item(30, 200000);
    drain();

    write_reg(pimt_pkg::RegPadK, 16'($urandom_range(1, 100)));
    write_reg(pimt_pkg::RegMinDepth, 16'hFFFF);
    for (int i = 0; i < 200; i++) random_item(20, 20000);
    drain();

    write_reg(pimt_pkg::RegPadK, 25);
    write_reg(pimt_pkg::RegMinDepth, 1);
    for (int i = 0; i < 300; i++) random_item(40, 5000);
    quiet = 1;
    for (int i = 0; i < 200; i++) random_item(45, 5000);
    drain();

    $display("sent %0d items: %0d merged, %0d full drops, %0d pops, %0d empty pops",
             n_sent, n_merged, n_full, n_popped, n_empty);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
